/* rtl/hmg_pkg.sv */
package hmg_pkg;

   localparam int NUM_COEFS = 18;
   localparam logic [4:0] BWD_BASE = 5'd9;
   localparam logic [4:0] FWD_BASE = 5'd0;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_MATCH = 1'b1;

   localparam logic [1:0] CSR_INV_SIGMA_SQ  = 2'd0;
   localparam logic [1:0] CSR_CHI_THRESHOLD = 2'd1;

   localparam logic [23:0] INV_SIGMA_SQ_RST  = 24'd65536;
   localparam logic [23:0] CHI_THRESHOLD_RST = 24'd392626;

   // Q12.8 one, used to pass the constant column through the multiplier
   localparam logic [19:0] PIX_ONE = 20'd256;

   localparam logic signed [31:0] DIFF_CAP_POS = 32'sd16777216;
   localparam logic signed [31:0] DIFF_CAP_NEG = -32'sd16777216;

   typedef logic [3:0] state_type;

endpackage

/* rtl/homography_inlier_scorer.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  mode, coef_index, coef_value, points, last_match
// rsp_      out        rsp_valid / rsp_stall  inlier, score, done_res
// csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A coefficient load writes one table entry. A match runs two transfer sides on one shared
// multiplier and one restoring divider (one quotient bit per cycle): each side forms its
// coefficient products, divides for x and y, then computes the distance and the test;
// a side with a zero denominator stops after its three denominator terms.
// Reset is synchronous and clears control state and the score; the CSR registers take their reset values.
// A stalled result holds the block in its final step; the next request waits meanwhile.
module homography_inlier_scorer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [4:0]          req_coef_index,
   input  logic signed [47:0]  req_coef_value,
   input  logic [19:0]         req_first_x,
   input  logic [19:0]         req_first_y,
   input  logic [19:0]         req_second_x,
   input  logic [19:0]         req_second_y,
   input  logic                req_last_match,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_inlier,
   output logic [31:0]         rsp_score,
   output logic                rsp_done_res,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   localparam hmg_pkg::state_type S_IDLE  = 4'd0;
   localparam hmg_pkg::state_type S_RD    = 4'd1;
   localparam hmg_pkg::state_type S_MUL   = 4'd2;
   localparam hmg_pkg::state_type S_ACC   = 4'd3;
   localparam hmg_pkg::state_type S_DIVI  = 4'd4;
   localparam hmg_pkg::state_type S_DIV   = 4'd5;
   localparam hmg_pkg::state_type S_SQX   = 4'd6;
   localparam hmg_pkg::state_type S_SQY   = 4'd7;
   localparam hmg_pkg::state_type S_DIST  = 4'd8;
   localparam hmg_pkg::state_type S_CHI   = 4'd9;
   localparam hmg_pkg::state_type S_JUDGE = 4'd10;

   hmg_pkg::state_type state_ff;

   logic [47:0]         coef_mem [hmg_pkg::NUM_COEFS];
   logic signed [47:0]  coef_rd_ff;
   logic [23:0]         inv_ff, thr_ff;
   logic [31:0]         score_ff;
   logic [19:0]         fx_ff, fy_ff, sx_ff, sy_ff;
   logic                last_ff, side_ff, fail_ff, pass0_ff, divsel_ff, neg_ff;
   logic [1:0]          k_ff, grp_ff;
   logic [4:0]          cnt_ff;
   logic signed [63:0]  acc_ff, den_ff, numx_ff, numy_ff;
   logic signed [74:0]  prod_ff;
   logic [69:0]         r_ff;
   logic [93:0]         d_ff;
   logic [30:0]         q_ff;
   logic signed [31:0]  ux_ff, uy_ff;
   logic [49:0]         dist_ff;
   logic                rsp_valid_ff, rsp_inlier_ff, rsp_done_ff;
   logic [31:0]         rsp_score_ff;

   logic                req_take, rsp_take, rsp_load;
   logic [19:0]         px, py, qx, qy, pix;
   logic [4:0]          rd_addr;
   logic [1:0]          row;
   logic signed [48:0]  mul_a;
   logic signed [25:0]  mul_b;
   logic signed [63:0]  term_sum;
   logic signed [63:0]  num_sel;
   logic [63:0]         num_abs, den_abs;
   logic                ge;
   logic [30:0]         q_in;
   logic [31:0]         mag;
   logic signed [31:0]  proj_in;
   logic signed [31:0]  diffx, diffy;
   logic signed [25:0]  dx, dy;
   logic [48:0]         chi;
   logic                side_fail;
   logic [23:0]         gain;
   logic [32:0]         sum33;
   logic [31:0]         score_in;
   logic                out_block;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign px = side_ff ? fx_ff : sx_ff;
   assign py = side_ff ? fy_ff : sy_ff;
   assign qx = side_ff ? sx_ff : fx_ff;
   assign qy = side_ff ? sy_ff : fy_ff;

   // denominator row first, then x and y numerator rows
   assign row     = (grp_ff == 2'd0) ? 2'd2 : grp_ff - 2'd1;
   assign rd_addr = (side_ff ? hmg_pkg::FWD_BASE : hmg_pkg::BWD_BASE)
                    + {1'b0, row, 2'b00} - {3'b000, row} + {3'b000, k_ff};

   always_comb begin
      case (k_ff)
         2'd0:    pix = px;
         2'd1:    pix = py;
         default: pix = hmg_pkg::PIX_ONE;
      endcase
   end

   always_comb begin
      diffx = $signed({12'b0, qx}) - ux_ff;
      diffy = $signed({12'b0, qy}) - uy_ff;
      if (diffx > hmg_pkg::DIFF_CAP_POS) diffx = hmg_pkg::DIFF_CAP_POS;
      if (diffx < hmg_pkg::DIFF_CAP_NEG) diffx = hmg_pkg::DIFF_CAP_NEG;
      if (diffy > hmg_pkg::DIFF_CAP_POS) diffy = hmg_pkg::DIFF_CAP_POS;
      if (diffy < hmg_pkg::DIFF_CAP_NEG) diffy = hmg_pkg::DIFF_CAP_NEG;
   end
   assign dx = diffx[25:0];
   assign dy = diffy[25:0];

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         S_SQX: begin
            mul_a = {{23{dx[25]}}, dx};
            mul_b = dx;
         end
         S_SQY: begin
            mul_a = {{23{dy[25]}}, dy};
            mul_b = dy;
         end
         S_CHI: begin
            mul_a = $signed({9'b0, dist_ff[39:0]});
            mul_b = $signed({2'b0, inv_ff});
         end
         default: begin
            mul_a = {coef_rd_ff[47], coef_rd_ff};
            mul_b = $signed({6'b0, pix});
         end
      endcase
   end

   assign term_sum = acc_ff + prod_ff[71:8];

   assign num_sel = divsel_ff ? numy_ff : numx_ff;
   assign num_abs = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
   assign den_abs = den_ff[63] ? 64'(-den_ff) : 64'(den_ff);

   assign ge      = ({24'b0, r_ff} >= d_ff);
   assign q_in    = {q_ff[29:0], ge};
   assign mag     = q_in[30] ? 32'h4000_0000 : {2'b00, q_in[29:0]};
   assign proj_in = neg_ff ? -$signed(mag) : $signed(mag);

   assign chi       = (inv_ff == 24'd0) ? 49'd0 : prod_ff[64:16];
   assign side_fail = fail_ff || ((inv_ff != 24'd0) && (dist_ff[49:40] != 10'd0))
                      || (chi > {25'b0, thr_ff});
   assign gain      = side_fail ? 24'd0 : thr_ff - chi[23:0];
   assign sum33     = {1'b0, score_ff} + {9'b0, gain};
   assign score_in  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
   assign out_block = rsp_valid_ff && rsp_stall;
   assign rsp_load  = (state_ff == S_JUDGE) && side_ff && !out_block;

   always_ff @(posedge clock) begin
      if (req_take && (req_mode == hmg_pkg::MODE_LOAD)
          && (req_coef_index < 5'(hmg_pkg::NUM_COEFS))) begin
         coef_mem[req_coef_index] <= req_coef_value;
      end
      coef_rd_ff <= coef_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inv_ff       <= hmg_pkg::INV_SIGMA_SQ_RST;
         thr_ff       <= hmg_pkg::CHI_THRESHOLD_RST;
         score_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
         side_ff      <= 1'b0;
         fail_ff      <= 1'b0;
         pass0_ff     <= 1'b0;
         divsel_ff    <= 1'b0;
         k_ff         <= 2'd0;
         grp_ff       <= 2'd0;
         cnt_ff       <= 5'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == hmg_pkg::CSR_INV_SIGMA_SQ) inv_ff <= csr_wdata;
            if (csr_index == hmg_pkg::CSR_CHI_THRESHOLD) thr_ff <= csr_wdata;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_take && (req_mode == hmg_pkg::MODE_MATCH)) begin
                  fx_ff    <= req_first_x;
                  fy_ff    <= req_first_y;
                  sx_ff    <= req_second_x;
                  sy_ff    <= req_second_y;
                  last_ff  <= req_last_match;
                  side_ff  <= 1'b0;
                  fail_ff  <= 1'b0;
                  k_ff     <= 2'd0;
                  grp_ff   <= 2'd0;
                  acc_ff   <= 64'sd0;
                  state_ff <= S_RD;
               end
            end
            S_RD:  state_ff <= S_MUL;
            S_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (k_ff != 2'd2) begin
                  acc_ff   <= term_sum;
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_RD;
               end else begin
                  acc_ff <= 64'sd0;
                  k_ff   <= 2'd0;
                  grp_ff <= grp_ff + 2'd1;
                  case (grp_ff)
                     2'd0: begin
                        den_ff <= term_sum;
                        if (term_sum == 64'sd0) begin
                           fail_ff  <= 1'b1;
                           state_ff <= S_JUDGE;
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     2'd1: begin
                        numx_ff  <= term_sum;
                        state_ff <= S_RD;
                     end
                     default: begin
                        numy_ff   <= term_sum;
                        divsel_ff <= 1'b0;
                        state_ff  <= S_DIVI;
                     end
                  endcase
               end
            end
            S_DIVI: begin
               r_ff     <= {num_abs[61:0], 8'b0};
               d_ff     <= {den_abs, 30'b0};
               neg_ff   <= num_sel[63] ^ den_ff[63];
               q_ff     <= 31'd0;
               cnt_ff   <= 5'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (ge) r_ff <= r_ff - d_ff[69:0];
               d_ff   <= {1'b0, d_ff[93:1]};
               q_ff   <= q_in;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd30) begin
                  if (divsel_ff) begin
                     uy_ff    <= proj_in;
                     state_ff <= S_SQX;
                  end else begin
                     ux_ff     <= proj_in;
                     divsel_ff <= 1'b1;
                     state_ff  <= S_DIVI;
                  end
               end
            end
            S_SQX: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               dist_ff  <= prod_ff[49:0];
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_DIST;
            end
            S_DIST: begin
               dist_ff  <= dist_ff + prod_ff[49:0];
               state_ff <= S_CHI;
            end
            S_CHI: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_JUDGE;
            end
            S_JUDGE: begin
               if (!side_ff) begin
                  score_ff <= score_in;
                  pass0_ff <= !side_fail;
                  side_ff  <= 1'b1;
                  fail_ff  <= 1'b0;
                  grp_ff   <= 2'd0;
                  k_ff     <= 2'd0;
                  acc_ff   <= 64'sd0;
                  state_ff <= S_RD;
               end else if (!out_block) begin
                  rsp_inlier_ff <= pass0_ff && !side_fail;
                  rsp_score_ff  <= score_in;
                  rsp_done_ff   <= last_ff;
                  score_ff      <= last_ff ? 32'd0 : score_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inlier   = rsp_inlier_ff;
   assign rsp_score    = rsp_score_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule
